// ===== rtl/stmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmd_pkg
// Shared types, codes and defaults of the sparse table range minimum block.
// ----------------------------------------------------------------------------
package stmd_pkg;

  // field widths of one transaction
  localparam int NODE_W  = 9;
  localparam int VALUE_W = 16;
  localparam int STAT_W  = 2;

  // default sizes
  localparam int MAX_NODES_DEF   = 512;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int LEVELS_DEF      = 11;

  // command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

  // datapath operation codes driven by the controller
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
  localparam logic [OP_W-1:0] OP_CAPTURE    = 4'd2;
  localparam logic [OP_W-1:0] OP_PUSH_FIRST = 4'd3;
  localparam logic [OP_W-1:0] OP_PUSH_LEVEL = 4'd4;
  localparam logic [OP_W-1:0] OP_RD_NODE_A  = 4'd5;
  localparam logic [OP_W-1:0] OP_RD_NODE_B  = 4'd6;
  localparam logic [OP_W-1:0] OP_NODES      = 4'd7;
  localparam logic [OP_W-1:0] OP_LEVEL      = 4'd8;
  localparam logic [OP_W-1:0] OP_RD_WIN_LO  = 4'd9;
  localparam logic [OP_W-1:0] OP_RD_WIN_HI  = 4'd10;
  localparam logic [OP_W-1:0] OP_RD_END_A   = 4'd11;
  localparam logic [OP_W-1:0] OP_RD_END_B   = 4'd12;
  localparam logic [OP_W-1:0] OP_CAP_EB     = 4'd13;
  localparam logic [OP_W-1:0] OP_DIST       = 4'd14;

  typedef struct packed {
    logic               cmd;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] distance;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic next_ok;
    logic node_ok;
    logic clr_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [VALUE_W-1:0] min16(input logic [VALUE_W-1:0] x,
                                              input logic [VALUE_W-1:0] y);
    min16 = (x < y) ? x : y;
  endfunction

endpackage

// ===== rtl/stmd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmd_ctrl
// Sequencer for the sparse table: clearing pass, push level walk, query steps
// and result hand-off.
// ----------------------------------------------------------------------------
module stmd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_cmd,
  output logic                  item_stall,
  input  stmd_pkg::dp_status_t  status,
  output stmd_pkg::ctl_cmd_t    ctl
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_PUSH_FIRST = 4'd2;
  localparam logic [3:0] S_PUSH_LEVEL = 4'd3;
  localparam logic [3:0] S_Q_RDA      = 4'd4;
  localparam logic [3:0] S_Q_RDB      = 4'd5;
  localparam logic [3:0] S_Q_CHK      = 4'd6;
  localparam logic [3:0] S_Q_LVL      = 4'd7;
  localparam logic [3:0] S_Q_WLO      = 4'd8;
  localparam logic [3:0] S_Q_WHI      = 4'd9;
  localparam logic [3:0] S_Q_ENA      = 4'd10;
  localparam logic [3:0] S_Q_ENB      = 4'd11;
  localparam logic [3:0] S_Q_EB       = 4'd12;
  localparam logic [3:0] S_Q_DIST     = 4'd13;
  localparam logic [3:0] S_EMIT       = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    ctl.op     = stmd_pkg::OP_NONE;
    ctl.emit   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctl.op = stmd_pkg::OP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          ctl.op     = stmd_pkg::OP_CAPTURE;
          state_next = (item_cmd == stmd_pkg::CMD_PUSH) ? S_PUSH_FIRST : S_Q_RDA;
        end
      end
      S_PUSH_FIRST: begin
        ctl.op     = stmd_pkg::OP_PUSH_FIRST;
        state_next = (status.full || !status.next_ok) ? S_EMIT : S_PUSH_LEVEL;
      end
      S_PUSH_LEVEL: begin
        ctl.op = stmd_pkg::OP_PUSH_LEVEL;
        if (!status.next_ok) state_next = S_EMIT;
      end
      S_Q_RDA: begin
        ctl.op     = stmd_pkg::OP_RD_NODE_A;
        state_next = S_Q_RDB;
      end
      S_Q_RDB: begin
        ctl.op     = stmd_pkg::OP_RD_NODE_B;
        state_next = S_Q_CHK;
      end
      S_Q_CHK: begin
        ctl.op     = stmd_pkg::OP_NODES;
        state_next = status.node_ok ? S_Q_LVL : S_EMIT;
      end
      S_Q_LVL: begin
        ctl.op     = stmd_pkg::OP_LEVEL;
        state_next = S_Q_WLO;
      end
      S_Q_WLO: begin
        ctl.op     = stmd_pkg::OP_RD_WIN_LO;
        state_next = S_Q_WHI;
      end
      S_Q_WHI: begin
        ctl.op     = stmd_pkg::OP_RD_WIN_HI;
        state_next = S_Q_ENA;
      end
      S_Q_ENA: begin
        ctl.op     = stmd_pkg::OP_RD_END_A;
        state_next = S_Q_ENB;
      end
      S_Q_ENB: begin
        ctl.op     = stmd_pkg::OP_RD_END_B;
        state_next = S_Q_EB;
      end
      S_Q_EB: begin
        ctl.op     = stmd_pkg::OP_CAP_EB;
        state_next = S_Q_DIST;
      end
      S_Q_DIST: begin
        ctl.op     = stmd_pkg::OP_DIST;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/stmd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmd_datapath
// Window minimum table, node position memory, working registers and the
// output register of the sparse table block.
// ----------------------------------------------------------------------------
module stmd_datapath #(
  parameter int MAX_NODES   = stmd_pkg::MAX_NODES_DEF,
  parameter int MAX_ENTRIES = stmd_pkg::MAX_ENTRIES_DEF,
  parameter int LEVELS      = stmd_pkg::LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stmd_pkg::item_t       item,
  input  stmd_pkg::ctl_cmd_t    ctl,
  output stmd_pkg::dp_status_t  status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output stmd_pkg::result_t     result
);

  localparam int NODE_SPACE = 2 ** stmd_pkg::NODE_W;
  localparam int NODE_DEPTH = (MAX_NODES < NODE_SPACE) ? MAX_NODES : NODE_SPACE;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int POS_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int TAB_DEPTH  = LEVELS * MAX_ENTRIES;
  localparam int TAB_AW     = $clog2(TAB_DEPTH);
  localparam int VW         = stmd_pkg::VALUE_W;

  // storage
  logic [VW-1:0]    tab_mem  [TAB_DEPTH];
  logic [POS_W:0]   node_mem [NODE_DEPTH];

  // control registers
  logic [CNT_W-1:0]   count;
  logic [NODE_AW-1:0] clr_cnt;

  // working registers
  stmd_pkg::item_t    it;
  stmd_pkg::result_t  res;
  logic [POS_W-1:0]   p;
  logic               full_r;
  logic [LVL_W-1:0]   lvl;
  logic [VW-1:0]      cur;
  logic               known_a;
  logic [POS_W-1:0]   pa;
  logic [POS_W-1:0]   pb;
  logic [POS_W-1:0]   lo;
  logic [POS_W-1:0]   hi;
  logic [CNT_W-1:0]   span;
  logic [VW-1:0]      m;
  logic [VW-1:0]      ea;
  logic [VW-1:0]      eb;

  // memory ports
  logic [VW-1:0]      tab_rdata;
  logic [TAB_AW-1:0]  tab_raddr;
  logic [TAB_AW-1:0]  tab_waddr;
  logic [VW-1:0]      tab_wdata;
  logic               tab_we;
  logic [POS_W:0]     node_rdata;
  logic [NODE_AW-1:0] node_raddr;
  logic [NODE_AW-1:0] node_waddr;
  logic [POS_W:0]     node_wdata;
  logic               node_we;

  // derived values
  logic [LVL_W:0]     lvl_up;
  logic               a_in;
  logic               b_in;
  logic [POS_W-1:0]   push_rd_pos;
  logic [POS_W-1:0]   win_lo_pos;
  logic [VW-1:0]      level_min;
  logic [POS_W-1:0]   pos_b;
  logic [VW-1:0]      dist_val;
  logic               out_free;

  function automatic logic [TAB_AW-1:0] tab_index(input logic [POS_W-1:0] pos,
                                                   input logic [LVL_W-1:0] lv);
    tab_index = TAB_AW'(lv) * TAB_AW'(MAX_ENTRIES) + TAB_AW'(pos);
  endfunction

  // largest power of two inside the span, clamped to the top level
  function automatic logic [LVL_W-1:0] span_level(input logic [CNT_W-1:0] s);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (s[i]) k = (i < LEVELS) ? LVL_W'(i) : LVL_W'(LEVELS - 1);
    end
    span_level = k;
  endfunction

  assign lvl_up      = (LVL_W + 1)'(lvl) + (LVL_W + 1)'(1);
  assign a_in        = (32'(it.node_a) < MAX_NODES);
  assign b_in        = (32'(it.node_b) < MAX_NODES);
  assign push_rd_pos = POS_W'(CNT_W'(p) - (CNT_W'(1) << lvl));
  assign win_lo_pos  = POS_W'(CNT_W'(lo) + (CNT_W'(1) << lvl) - CNT_W'(1));
  assign level_min   = stmd_pkg::min16(tab_rdata, cur);
  assign pos_b       = node_rdata[POS_W-1:0];
  assign out_free    = !result_valid || !result_stall;

  // distance from end values and range minimum
  always_comb begin
    dist_val = (ea >> 1) + (eb >> 1) - {m[VW-1:1], 1'b0};
    if (m[0] && (m != ea) && (m != eb)) dist_val = dist_val - VW'(1);
  end

  // status to controller
  assign status.full     = full_r;
  assign status.next_ok  = (32'(lvl_up) < LEVELS) &&
                           (((CNT_W'(p) + CNT_W'(1)) >> lvl_up) != '0);
  assign status.node_ok  = a_in && b_in && known_a && node_rdata[POS_W];
  assign status.clr_last = (32'(clr_cnt) == NODE_DEPTH - 1);
  assign status.out_free = out_free;

  // table port selection
  always_comb begin
    tab_raddr = tab_index(push_rd_pos, lvl);
    tab_waddr = tab_index(p, lvl);
    tab_wdata = it.value;
    tab_we    = 1'b0;
    case (ctl.op)
      stmd_pkg::OP_PUSH_FIRST: begin
        tab_we = !full_r;
      end
      stmd_pkg::OP_PUSH_LEVEL: begin
        tab_wdata = level_min;
        tab_we    = 1'b1;
      end
      stmd_pkg::OP_RD_WIN_LO: tab_raddr = tab_index(win_lo_pos, lvl);
      stmd_pkg::OP_RD_WIN_HI: tab_raddr = tab_index(hi, lvl);
      stmd_pkg::OP_RD_END_A:  tab_raddr = tab_index(pa, '0);
      stmd_pkg::OP_RD_END_B:  tab_raddr = tab_index(pb, '0);
      default: ;
    endcase
  end

  // node memory port selection
  always_comb begin
    node_raddr = it.node_a[NODE_AW-1:0];
    node_waddr = it.node_a[NODE_AW-1:0];
    node_wdata = {1'b1, p};
    node_we    = 1'b0;
    case (ctl.op)
      stmd_pkg::OP_CLEAR: begin
        node_waddr = clr_cnt;
        node_wdata = '0;
        node_we    = 1'b1;
      end
      stmd_pkg::OP_PUSH_FIRST: node_we = !full_r && a_in;
      stmd_pkg::OP_RD_NODE_B:  node_raddr = it.node_b[NODE_AW-1:0];
      default: ;
    endcase
  end

  // window minimum table
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rdata <= tab_mem[tab_raddr];
  end

  // node position memory, known flag on top
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.op == stmd_pkg::OP_CLEAR) clr_cnt <= clr_cnt + NODE_AW'(1);
      if (ctl.op == stmd_pkg::OP_PUSH_FIRST && !full_r) count <= count + CNT_W'(1);
      if (ctl.emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.emit) result <= res;
  end

  // working registers per step, table data lands in the cycle after its address
  always_ff @(posedge clk) begin
    case (ctl.op)
      stmd_pkg::OP_CAPTURE: begin
        it     <= item;
        p      <= POS_W'(count);
        full_r <= (32'(count) == MAX_ENTRIES);
        lvl    <= '0;
      end
      stmd_pkg::OP_PUSH_FIRST: begin
        cur <= it.value;
        lvl <= LVL_W'(lvl_up);
        res <= '{status: full_r ? stmd_pkg::STATUS_FULL : stmd_pkg::STATUS_OK,
                 distance: '0};
      end
      stmd_pkg::OP_PUSH_LEVEL: begin
        cur <= level_min;
        lvl <= LVL_W'(lvl_up);
      end
      stmd_pkg::OP_RD_NODE_B: begin
        known_a <= node_rdata[POS_W];
        pa      <= node_rdata[POS_W-1:0];
      end
      stmd_pkg::OP_NODES: begin
        pb   <= pos_b;
        lo   <= (pa < pos_b) ? pa : pos_b;
        hi   <= (pa < pos_b) ? pos_b : pa;
        span <= (pa < pos_b) ? (CNT_W'(pos_b) - CNT_W'(pa) + CNT_W'(1))
                             : (CNT_W'(pa) - CNT_W'(pos_b) + CNT_W'(1));
        res  <= '{status: stmd_pkg::STATUS_UNKNOWN, distance: '0};
      end
      stmd_pkg::OP_LEVEL:     lvl <= span_level(span);
      stmd_pkg::OP_RD_WIN_HI: m   <= tab_rdata;
      stmd_pkg::OP_RD_END_A:  m   <= stmd_pkg::min16(m, tab_rdata);
      stmd_pkg::OP_RD_END_B:  ea  <= tab_rdata;
      stmd_pkg::OP_CAP_EB:    eb  <= tab_rdata;
      stmd_pkg::OP_DIST: begin
        res <= '{status: stmd_pkg::STATUS_OK, distance: dist_val};
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sparse_table_min_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_min_distance
// Append-only sparse table for range minimum with a node distance query.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, with the table and node memories
// each doing one read per cycle. A push writes its entry and then builds
// L = min(floor(log2(p+1)), LEVELS-1) window levels at one level per cycle
// for position p before it hands on its status; a push into a full table
// writes nothing. A query does its two node lookups and four table reads,
// and stops after the node lookups when a node is unknown. After reset the
// block runs a clearing pass over the min(MAX_NODES, 512) node memory
// entries with item_stall high. A finished result sits in an output
// register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module sparse_table_min_distance #(
  parameter int MAX_NODES   = stmd_pkg::MAX_NODES_DEF,
  parameter int MAX_ENTRIES = stmd_pkg::MAX_ENTRIES_DEF,
  parameter int LEVELS      = stmd_pkg::LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  stmd_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_stall,
  output stmd_pkg::result_t  result
);

  stmd_pkg::ctl_cmd_t   ctl;
  stmd_pkg::dp_status_t status;

  // sequencer
  stmd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_cmd   (item.cmd),
    .item_stall (item_stall),
    .status     (status),
    .ctl        (ctl)
  );

  // memories and arithmetic
  stmd_datapath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_ENTRIES (MAX_ENTRIES),
    .LEVELS      (LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/stmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmd_checker
// Port level checks of the sparse table block, bound to the top level.
// ----------------------------------------------------------------------------
module stmd_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input stmd_pkg::item_t    item,
  input logic               result_valid,
  input logic               result_stall,
  input stmd_pkg::result_t  result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == stmd_pkg::STATUS_OK ||
                      result.status == stmd_pkg::STATUS_UNKNOWN ||
                      result.status == stmd_pkg::STATUS_FULL))
    else $error("undefined status code");

  // error results carry no distance
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != stmd_pkg::STATUS_OK |-> result.distance == '0)
    else $error("error result with nonzero distance");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted back to back");

  // a query does not finish early: the input is still stalled partway through it
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.cmd == stmd_pkg::CMD_QUERY |=>
      ##2 item_stall)
    else $error("query finished too early");

endmodule

bind sparse_table_min_distance stmd_checker u_stmd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse table range minimum distance block.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the window minimum table, the node
// positions and the entry count. From each accepted transaction it works out
// the status and distance that should come back, and checks every result
// against the oldest answer still due. The stimulus opens with a directed
// sequence (unknown nodes, repeated nodes, extreme values, odd minimum cases)
// and then runs random pushes and queries until the table is full and pushes
// start to be dropped. Both handshakes idle and stall at random, in three
// phases with different idle rates, and the receiver holds off once for a
// long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb;
  import stmd_pkg::*;

  localparam int N_NODES     = MAX_NODES_DEF;
  localparam int N_ENTRIES   = MAX_ENTRIES_DEF;
  localparam int N_LEVELS    = LEVELS_DEF;
  localparam int POS_W       = $clog2(N_ENTRIES);
  localparam int N_RANDOM    = 1880;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  // reference copy of the table and the answers still due
  class rmq_scoreboard;
    logic [VALUE_W-1:0] win_min [N_ENTRIES][N_LEVELS];
    logic [POS_W-1:0]   pos_of [N_NODES];
    bit                 known [N_NODES];
    int unsigned        used;
    result_t            answers_due[$];
    int unsigned        errors;
    int unsigned        n_appended, n_dropped, n_answered, n_unknown;

    function result_t expected_answer(item_t it);
      result_t     r;
      int unsigned p, lvl, lo, hi, span, pa, pb, ea, eb, m, w_lo, w_hi, d;
      r = '0;
      if (it.cmd == CMD_PUSH) begin
        // append, unless the table is already full
        if (used >= N_ENTRIES) begin
          r.status = STATUS_FULL;
          n_dropped++;
          return r;
        end
        p = used;
        win_min[p][0] = it.value;
        for (lvl = 1; lvl < N_LEVELS && (1 << lvl) <= p + 1; lvl++) begin
          w_lo = 32'(win_min[p - (1 << (lvl - 1))][lvl - 1]);
          w_hi = 32'(win_min[p][lvl - 1]);
          win_min[p][lvl] = VALUE_W'((w_lo < w_hi) ? w_lo : w_hi);
        end
        pos_of[it.node_a] = POS_W'(p);
        known[it.node_a] = 1'b1;
        used = p + 1;
        n_appended++;
        return r;
      end
      // query of a node that was never pushed
      if (!known[it.node_a] || !known[it.node_b]) begin
        r.status = STATUS_UNKNOWN;
        n_unknown++;
        return r;
      end
      pa = 32'(pos_of[it.node_a]);
      pb = 32'(pos_of[it.node_b]);
      lo = (pa < pb) ? pa : pb;
      hi = (pa < pb) ? pb : pa;
      span = hi - lo + 1;
      // largest power-of-two window that fits the span, clamped to the top level
      lvl = 0;
      while ((span >> (lvl + 1)) != 0) lvl++;
      if (lvl >= N_LEVELS) lvl = N_LEVELS - 1;
      w_lo = 32'(win_min[lo + (1 << lvl) - 1][lvl]);
      w_hi = 32'(win_min[hi][lvl]);
      m = (w_lo < w_hi) ? w_lo : w_hi;
      ea = 32'(win_min[pa][0]);
      eb = 32'(win_min[pb][0]);
      d = ea / 2 + eb / 2 - 2 * (m / 2);
      if (m[0] && m != ea && m != eb) d = d - 1;
      r.distance = d[VALUE_W-1:0];
      n_answered++;
      return r;
    endfunction

    function void note_accepted(item_t it);
      answers_due = {answers_due, expected_answer(it)};
    endfunction

    function void check_answer(result_t got);
      result_t exp;
      if (answers_due.size() == 0) begin
        $error("unexpected result: status %0d distance %0d", got.status, got.distance);
        errors++;
        return;
      end
      exp = answers_due.pop_front();
      if (got.status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.distance !== exp.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", exp.distance, got.distance);
        errors++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function void close_out();
      if (answers_due.size() != 0) begin
        $error("%0d results never arrived", answers_due.size());
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  rmq_scoreboard sb;
  int          send_idle_pct = 25;
  int          stall_pct = 77;
  int unsigned hold_reqs = 0;
  logic [NODE_W-1:0] pushed[$];

  sparse_table_min_distance #(
    .MAX_NODES  (N_NODES),
    .MAX_ENTRIES(N_ENTRIES),
    .LEVELS     (N_LEVELS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_side
    int          hold_left;
    int unsigned holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall = 1'b1;
      end else begin
        result_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) sb.check_answer(result);
  end

  // offer one transaction and hold it until accepted
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    sb.note_accepted(it);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding answer
  task automatic drain();
    item_valid = 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic item_t make_item(logic cmd, int a, int b, int v);
    item_t it;
    it.cmd = cmd;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.value = VALUE_W'(v);
    return it;
  endfunction

  // a pushed node, often one of the latest so that short spans come up too
  function automatic logic [NODE_W-1:0] pick_known();
    if (pushed.size() > 8 && $urandom_range(2) == 0)
      return pushed[pushed.size() - 1 - $urandom_range(7)];
    return pushed[$urandom_range(pushed.size() - 1)];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    push_pct;
    it.cmd = CMD_QUERY;
    it.node_a = NODE_W'($urandom);
    it.node_b = NODE_W'($urandom);
    it.value = VALUE_W'($urandom);
    push_pct = (sb.used < N_ENTRIES) ? 62 : 15;
    if ($urandom_range(99) < push_pct) begin
      it.cmd = CMD_PUSH;
      case ($urandom_range(7))
        0: it.value = '0;
        1: it.value = '1;
        2, 3: it.value = VALUE_W'($urandom_range(31));
        default: it.value = VALUE_W'($urandom);
      endcase
      if (sb.used < N_ENTRIES) pushed = {pushed, it.node_a};
    end else if (pushed.size() > 0 && $urandom_range(99) < 85) begin
      it.node_a = pick_known();
      it.node_b = pick_known();
      if ($urandom_range(19) == 0) it.node_b = it.node_a;
    end
    return it;
  endfunction

  task automatic random_phase(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) send_item(random_item());
    drain();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: unknown nodes, extremes, repeated node, odd minimum cases
    send_item(make_item(CMD_QUERY, 0, 0, 16'hFFFF));
    send_item(make_item(CMD_PUSH, 0, 511, 16'hFFFF));
    send_item(make_item(CMD_QUERY, 0, 0, 0));
    send_item(make_item(CMD_QUERY, 0, 5, 0));
    send_item(make_item(CMD_QUERY, 5, 0, 0));
    send_item(make_item(CMD_PUSH, 511, 0, 16'h0000));
    send_item(make_item(CMD_QUERY, 0, 511, 0));
    send_item(make_item(CMD_PUSH, 5, 0, 16'h0001));
    send_item(make_item(CMD_PUSH, 6, 0, 16'h8000));
    send_item(make_item(CMD_PUSH, 7, 0, 16'h0003));
    send_item(make_item(CMD_PUSH, 8, 0, 16'h7FFF));
    send_item(make_item(CMD_QUERY, 511, 8, 0));
    send_item(make_item(CMD_QUERY, 0, 7, 0));
    send_item(make_item(CMD_QUERY, 6, 8, 0));
    send_item(make_item(CMD_QUERY, 7, 8, 0));
    send_item(make_item(CMD_QUERY, 5, 6, 0));
    send_item(make_item(CMD_PUSH, 5, 0, 16'h1234));
    send_item(make_item(CMD_QUERY, 5, 0, 0));
    send_item(make_item(CMD_QUERY, 8, 5, 0));
    send_item(make_item(CMD_QUERY, 511, 511, 0));
    send_item(make_item(CMD_PUSH, 300, 0, 16'hAAAA));
    send_item(make_item(CMD_PUSH, 301, 0, 16'h5555));
    send_item(make_item(CMD_QUERY, 0, 301, 0));
    send_item(make_item(CMD_QUERY, 301, 511, 16'hFFFF));
    drain();
    pushed = '{0, 511, 5, 6, 7, 8, 5, 300, 301};

    // random traffic in three idle patterns
    random_phase(N_RANDOM / 3, 25, 77);
    random_phase(N_RANDOM / 3, 77, 25);
    hold_reqs++;
    random_phase(N_RANDOM - 2 * (N_RANDOM / 3), 0, 0);

    repeat (TAIL_CYCLES) @(negedge clk);
    sb.close_out();
    $display("covered %0d appends, %0d appends dropped on a full table,",
             sb.n_appended, sb.n_dropped);
    $display("%0d distance queries answered and %0d queries of unknown nodes",
             sb.n_answered, sb.n_unknown);
    if (sb.errors == 0) begin
      $display("** sparse_table_min_distance: PASSED **");
    end else begin
      $display("** sparse_table_min_distance: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("** sparse_table_min_distance: FAILED **");
    $finish;
  end

endmodule
